>>> sv/pwl_pkg.sv
package pwl_pkg;

  localparam int VAL_W      = 32;
  localparam int NUM_VALUES = 3;
  localparam int ROW_W      = NUM_VALUES * VAL_W;
  // Quotient never exceeds 33 bits, so the divider runs 33 restoring steps.
  localparam int DIV_STEPS  = 33;
  localparam int STEP_W     = 6;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] REGION_INTERP = 2'd0;
  localparam logic [1:0] REGION_BELOW  = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;
  localparam logic [1:0] REGION_FLAT   = 2'd3;

  localparam logic [1:0] SEL_PRESSURE    = 2'd0;
  localparam logic [1:0] SEL_TEMPERATURE = 2'd1;
  localparam logic [1:0] SEL_DENSITY     = 2'd2;

  typedef struct packed {
    logic               func;
    logic [4:0]         row_index;
    logic signed [31:0] breakpoint_height;
    logic signed [31:0] load_pressure;
    logic signed [31:0] load_temperature;
    logic signed [31:0] load_density;
    logic signed [31:0] query_altitude;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pressure_out;
    logic signed [31:0] temperature_out;
    logic signed [31:0] density_out;
    logic [1:0]         region;
  } out_item_t;

  typedef struct packed {
    logic       write_row;
    logic       latch_alt;
    logic       save_prev;
    logic       take_bracket;
    logic       take_vlo;
    logic       take_vhi;
    logic       copy_lo;
    logic       mul_load;
    logic       div_step;
    logic       store_res;
    logic [1:0] sel;
    logic       publish;
    logic [1:0] region;
  } cmd_t;

  typedef struct packed {
    logic alt_lt_h;
    logic dh_pos;
    logic out_free;
  } status_t;

endpackage

>>> sv/pwl_stream_if.sv
interface pwl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/pwl_ram.sv
module pwl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/pwl_dp.sv
module pwl_dp
  import pwl_pkg::*;
#(
  parameter int TABLE_ROWS = 32,
  localparam int AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  input  logic [AW-1:0] h_addr,
  input  logic [AW-1:0] v_addr,
  input  in_item_t      item,
  output status_t       status,
  output out_item_t     rsp_data,
  output logic          rsp_valid,
  input  logic          rsp_ready
);
  logic [AW+4:0]      ridx_ext;
  logic               wr_en;
  logic [31:0]        h_rdata;
  logic [ROW_W-1:0]   v_rdata;

  logic signed [31:0] alt;
  logic signed [31:0] hprev;
  logic signed [31:0] hlo;
  logic signed [31:0] hhi;
  logic [ROW_W-1:0]   vlo;
  logic [ROW_W-1:0]   vhi;
  logic [31:0]        res [NUM_VALUES];
  logic [31:0]        rem;
  logic [32:0]        quo;
  logic               neg;

  logic [32:0]        dh;
  logic [31:0]        dhu;
  logic [32:0]        off_full;
  logic [31:0]        off;
  logic [31:0]        vlo_sel;
  logic [31:0]        vhi_sel;
  logic [32:0]        dv;
  logic [32:0]        mag;
  logic [64:0]        prod_c;
  logic [32:0]        trial;
  logic               ge;
  logic [31:0]        res_val;

  assign ridx_ext = (AW + 5)'(item.row_index);
  assign wr_en    = cmd.write_row && ({27'b0, item.row_index} < 32'(TABLE_ROWS));

  pwl_ram #(.WIDTH(32), .DEPTH(TABLE_ROWS)) u_hram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ridx_ext[AW-1:0]),
    .wdata (item.breakpoint_height),
    .raddr (h_addr),
    .rdata (h_rdata)
  );

  pwl_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ROWS)) u_vram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ridx_ext[AW-1:0]),
    .wdata ({item.load_pressure, item.load_temperature, item.load_density}),
    .raddr (v_addr),
    .rdata (v_rdata)
  );

  assign dh       = {hhi[31], hhi} - {hlo[31], hlo};
  assign dhu      = dh[31:0];
  assign off_full = {alt[31], alt} - {hlo[31], hlo};
  assign off      = off_full[31:0];

  always_comb begin
    case (cmd.sel)
      SEL_PRESSURE: begin
        vlo_sel = vlo[95:64];
        vhi_sel = vhi[95:64];
      end
      SEL_TEMPERATURE: begin
        vlo_sel = vlo[63:32];
        vhi_sel = vhi[63:32];
      end
      default: begin
        vlo_sel = vlo[31:0];
        vhi_sel = vhi[31:0];
      end
    endcase
  end

  assign dv      = {vhi_sel[31], vhi_sel} - {vlo_sel[31], vlo_sel};
  assign mag     = dv[32] ? (33'd0 - dv) : dv;
  assign prod_c  = 65'(off) * 65'(mag);
  assign trial   = {rem, quo[32]};
  assign ge      = trial >= {1'b0, dhu};
  assign res_val = neg ? (vlo_sel - quo[31:0]) : (vlo_sel + quo[31:0]);

  assign status.alt_lt_h = alt < $signed(h_rdata);
  assign status.dh_pos   = !dh[32] && (dh != 33'd0);
  assign status.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch_alt) begin
      alt <= item.query_altitude;
    end
    if (cmd.save_prev) begin
      hprev <= $signed(h_rdata);
    end
    if (cmd.take_bracket) begin
      hlo <= hprev;
      hhi <= $signed(h_rdata);
    end
    if (cmd.take_vlo) begin
      vlo <= v_rdata;
    end
    if (cmd.take_vhi) begin
      vhi <= v_rdata;
    end
    if (cmd.copy_lo) begin
      res[0] <= vlo[95:64];
      res[1] <= vlo[63:32];
      res[2] <= vlo[31:0];
    end
    if (cmd.mul_load) begin
      rem <= prod_c[64:33];
      quo <= prod_c[32:0];
      neg <= dv[32];
    end else if (cmd.div_step) begin
      rem <= ge ? 32'(trial - {1'b0, dhu}) : trial[31:0];
      quo <= {quo[31:0], ge};
    end
    if (cmd.store_res) begin
      res[cmd.sel] <= res_val;
    end
    if (cmd.publish) begin
      rsp_data.pressure_out    <= res[0];
      rsp_data.temperature_out <= res[1];
      rsp_data.density_out     <= res[2];
      rsp_data.region          <= cmd.region;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.publish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end
endmodule

>>> sv/pwl_ctrl.sv
module pwl_ctrl
  import pwl_pkg::*;
#(
  parameter int TABLE_ROWS = 32,
  localparam int AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_func,
  output logic          req_ready,
  input  status_t       status,
  output cmd_t          cmd,
  output logic [AW-1:0] h_addr,
  output logic [AW-1:0] v_addr
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK0  = 4'd1;
  localparam logic [3:0] S_CHKN  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_VREQ  = 4'd4;
  localparam logic [3:0] S_VLO   = 4'd5;
  localparam logic [3:0] S_COPY  = 4'd6;
  localparam logic [3:0] S_VHI   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_STORE = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  localparam logic [AW-1:0] LAST_ROW = AW'(TABLE_ROWS - 1);

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     idx_next;
  logic [AW-1:0]     lo;
  logic [AW-1:0]     lo_next;
  logic [1:0]        region;
  logic [1:0]        region_next;
  logic [1:0]        sel;
  logic [1:0]        sel_next;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    lo_next     = lo;
    region_next = region;
    sel_next    = sel;
    cnt_next    = cnt;
    cmd         = '0;
    cmd.sel     = sel;
    cmd.region  = region;
    req_ready   = 1'b0;
    h_addr      = '0;
    v_addr      = lo + AW'(1);

    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_func == FUNC_LOAD) begin
            cmd.write_row = 1'b1;
          end else begin
            cmd.latch_alt = 1'b1;
            state_next    = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        cmd.save_prev = 1'b1;
        h_addr        = LAST_ROW;
        if (status.alt_lt_h) begin
          lo_next     = '0;
          region_next = REGION_BELOW;
          state_next  = S_VREQ;
        end else begin
          state_next  = S_CHKN;
        end
      end
      S_CHKN: begin
        h_addr   = AW'(1);
        idx_next = AW'(1);
        if (!status.alt_lt_h) begin
          lo_next     = LAST_ROW;
          region_next = REGION_ABOVE;
          state_next  = S_VREQ;
        end else begin
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        h_addr = idx + AW'(1);
        if (status.alt_lt_h) begin
          cmd.take_bracket = 1'b1;
          lo_next          = idx - AW'(1);
          region_next      = REGION_INTERP;
          state_next       = S_VREQ;
        end else begin
          cmd.save_prev = 1'b1;
          idx_next      = idx + AW'(1);
        end
      end
      S_VREQ: begin
        v_addr     = lo;
        state_next = S_VLO;
      end
      S_VLO: begin
        cmd.take_vlo = 1'b1;
        if (region != REGION_INTERP) begin
          state_next = S_COPY;
        end else if (!status.dh_pos) begin
          region_next = REGION_FLAT;
          state_next  = S_COPY;
        end else begin
          state_next  = S_VHI;
        end
      end
      S_COPY: begin
        cmd.copy_lo = 1'b1;
        state_next  = S_DONE;
      end
      S_VHI: begin
        cmd.take_vhi = 1'b1;
        sel_next     = SEL_PRESSURE;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + STEP_W'(1);
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store_res = 1'b1;
        if (sel == SEL_DENSITY) begin
          state_next = S_DONE;
        end else begin
          sel_next   = sel + 2'd1;
          state_next = S_MUL;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      idx    <= '0;
      lo     <= '0;
      region <= REGION_INTERP;
      sel    <= SEL_PRESSURE;
      cnt    <= '0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      lo     <= lo_next;
      region <= region_next;
      sel    <= sel_next;
      cnt    <= cnt_next;
    end
  end
endmodule

>>> sv/piecewise_linear_table_interp.sv
// Channel  Dir  Payload     Transaction
// -------  ---  ----------  ---------------------------------------------------
// req      in   in_item_t   func 0 writes one table row, func 1 is a query
// rsp      out  out_item_t  interpolated pressure/temperature/density + region
//
// A load transaction is written straight from idle; the next transaction is
// taken right after. An interpolating query scans k rows, k being the scan
// length (1 to TABLE_ROWS-1, one height-RAM read per row); a query clamped
// below or above skips the scan and the divisions. Three 33-step restoring
// divisions, one quotient bit per cycle, make up most of an interpolating
// query. rst is synchronous and clears control only; table contents are
// undefined until written. A stalled rsp holds its result in the output
// register while the next request is already being worked on.
module piecewise_linear_table_interp
  import pwl_pkg::*;
#(
  parameter int TABLE_ROWS = 32
) (
  input logic         clk,
  input logic         rst,
  pwl_stream_if.sink   req,
  pwl_stream_if.source rsp
);
  localparam int AW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] h_addr;
  logic [AW-1:0] v_addr;
  in_item_t      item;
  out_item_t     rsp_item;

  assign item     = req.data;
  assign rsp.data = rsp_item;

  // Sequencer: bracket search over the height RAM, then row fetch and divide.
  pwl_ctrl #(.TABLE_ROWS(TABLE_ROWS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (item.func),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd),
    .h_addr    (h_addr),
    .v_addr    (v_addr)
  );

  // Table RAMs, multiplier, bit-serial divider and the output register.
  pwl_dp #(.TABLE_ROWS(TABLE_ROWS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .h_addr    (h_addr),
    .v_addr    (v_addr),
    .item      (item),
    .status    (status),
    .rsp_data  (rsp_item),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
  );
endmodule
